/* hw/rtl/delta_rule_choice_probability_macros.svh */
// Assertion macros shared by the checker of the delta-rule choice block.
// Needs nothing else; take it by include where assertions are written.
`ifndef DELTA_RULE_CHOICE_PROBABILITY_MACROS_SVH
`define DELTA_RULE_CHOICE_PROBABILITY_MACROS_SVH

// Clocked check, muted while reset is high.
`define DRCP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset.
`define DRCP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/drcp_pkg.sv */
// Shared types and constants of the delta-rule choice block.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package drcp_pkg;

   // Configuration register map
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_A   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_B   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_TEMP = 2'd3;

   localparam int FIELD_W = 32;  // reward and value ports, Q16.16
   localparam int RATE_W  = 17;  // Q1.16, one point zero is RATE_ONE
   localparam int TEMP_W  = 24;  // Q8.16
   localparam int PROB_W  = 16;  // Q0.16

   localparam logic [RATE_W-1:0] RATE_ONE       = 17'd65536;
   localparam logic [TEMP_W-1:0] INV_TEMP_RESET = 24'd65536;

   // Value difference is clamped to +-2^38 and carried in CLAMP_W bits
   localparam int CLAMP_W = 40;
   localparam int LOGIT_W = 48;

   // Piecewise-linear logistic knees on |x|, Q16.16
   localparam logic [LOGIT_W-1:0] KNEE_ONE  = 48'd65536;
   localparam logic [LOGIT_W-1:0] KNEE_TWO  = 48'd155648;
   localparam logic [LOGIT_W-1:0] KNEE_FIVE = 48'd327680;
   localparam logic [16:0] OFFSET_ONE   = 17'd32768;
   localparam logic [16:0] OFFSET_TWO   = 17'd40960;
   localparam logic [16:0] OFFSET_THREE = 17'd55296;
   localparam logic [16:0] PROB_UNITY   = 17'd65536;
   localparam logic [16:0] PROB_MAX     = 17'd65535;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_UPDATE,
      BACK_SCALE,
      BACK_EMIT
   } back_state_type;

   function automatic logic [PROB_W-1:0] logistic_q16(input logic signed [LOGIT_W-1:0] x);
      logic [LOGIT_W-1:0] ax;
      logic [16:0] y;
      ax = x[LOGIT_W-1] ? LOGIT_W'(-x) : LOGIT_W'(x);
      if (ax < KNEE_ONE) begin
         y = 17'(ax >> 2) + OFFSET_ONE;
      end else if (ax < KNEE_TWO) begin
         y = 17'(ax >> 3) + OFFSET_TWO;
      end else if (ax < KNEE_FIVE) begin
         y = 17'(ax >> 5) + OFFSET_THREE;
      end else begin
         y = PROB_UNITY;
      end
      if (x[LOGIT_W-1]) begin
         y = PROB_UNITY - y;
      end
      if (y > PROB_MAX) begin
         y = PROB_MAX;
      end
      return y[PROB_W-1:0];
   endfunction

endpackage

/* hw/rtl/delta_rule_choice_probability.sv */
// Top level of the delta-rule learner with logistic choice probability.
// Depends on drcp_pkg, drcp_front, drcp_queue and drcp_back.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------------
//   req     | in        | req_valid/req_stall  | first_trial, chose_b, reward_value
//   rsp     | out       | rsp_valid/rsp_stall  | prob_b, value_a_out, value_b_out
//   csr     | in        | csr_wr_en            | csr_index, csr_wdata (no read-back)
//
// Each request passes through the four steps of the back-end sequencer (partial
// products, value update, logit multiply, logistic into the response register),
// one request at a time: the next starts only after the last has left its final
// step. Reset is synchronous: it empties the queue, zeroes both option values and
// restores the register defaults. A stalled response holds the sequencer in its
// last step; the two-entry queue keeps taking requests until it fills.
`timescale 1ns / 1ps

module delta_rule_choice_probability #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_first_trial,
   input  logic                                  req_chose_b,
   input  logic signed [drcp_pkg::FIELD_W-1:0]   req_reward_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [drcp_pkg::PROB_W-1:0]           rsp_prob_b,
   output logic signed [drcp_pkg::FIELD_W-1:0]   rsp_value_a_out,
   output logic signed [drcp_pkg::FIELD_W-1:0]   rsp_value_b_out,
   input  logic                                  csr_wr_en,
   input  logic [drcp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [drcp_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import drcp_pkg::*;

   // Queue entry: first-trial flag, choice, saturated reward
   localparam int ENTRY_W = VALUE_WIDTH + 2;

   q_status_type                  q_status;
   logic                          q_push, q_pop;
   logic [ENTRY_W-1:0]            q_push_data, q_pop_data;
   logic signed [VALUE_WIDTH-1:0] init_a_sat, init_b_sat;
   logic [RATE_W-1:0]             rate_eff;
   logic signed [TEMP_W-1:0]      inv_temp;

   // Front end: registers and request intake. Saturation of the reward and
   // of the initial values to the stored width happens here, so the back end
   // only ever sees values in range.
   drcp_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_first_trial  (req_first_trial),
      .req_chose_b      (req_chose_b),
      .req_reward_value (req_reward_value),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_push_data      (q_push_data),
      .init_a_sat       (init_a_sat),
      .init_b_sat       (init_b_sat),
      .rate_eff         (rate_eff),
      .inv_temp         (inv_temp)
   );

   // Decouple intake from the sequencer so either side may stall alone
   drcp_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // Back end: one request at a time through the four-step sequencer; the
   // option values live here and carry over from one request to the next.
   drcp_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .q_pop           (q_pop),
      .q_pop_data      (q_pop_data),
      .init_a_sat      (init_a_sat),
      .init_b_sat      (init_b_sat),
      .rate_eff        (rate_eff),
      .inv_temp        (inv_temp),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_prob_b      (rsp_prob_b),
      .rsp_value_a_out (rsp_value_a_out),
      .rsp_value_b_out (rsp_value_b_out)
   );

endmodule

/* hw/rtl/drcp_queue.sv */
// Short register queue between the front and back ends.
// Depends on drcp_pkg for depth and status type.
`timescale 1ns / 1ps

module drcp_queue #(
   parameter int WIDTH = 34
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [WIDTH-1:0]         push_data,
   input  logic                     pop,
   output logic [WIDTH-1:0]         pop_data,
   output drcp_pkg::q_status_type   status
);
   import drcp_pkg::*;

   logic [WIDTH-1:0]  entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/drcp_front.sv */
// Front end: configuration registers, request acceptance and classification.
// Depends on drcp_pkg; feeds drcp_queue.
`timescale 1ns / 1ps

module drcp_front #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_first_trial,
   input  logic                                  req_chose_b,
   input  logic signed [drcp_pkg::FIELD_W-1:0]   req_reward_value,
   input  logic                                  csr_wr_en,
   input  logic [drcp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [drcp_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  drcp_pkg::q_status_type                q_status,
   output logic                                  q_push,
   output logic [VALUE_WIDTH+1:0]                q_push_data,
   output logic signed [VALUE_WIDTH-1:0]         init_a_sat,
   output logic signed [VALUE_WIDTH-1:0]         init_b_sat,
   output logic [drcp_pkg::RATE_W-1:0]           rate_eff,
   output logic signed [drcp_pkg::TEMP_W-1:0]    inv_temp
);
   import drcp_pkg::*;

   localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

   logic signed [FIELD_W-1:0] init_a_ff, init_a_in;
   logic signed [FIELD_W-1:0] init_b_ff, init_b_in;
   logic [RATE_W-1:0]         rate_ff, rate_in;
   logic signed [TEMP_W-1:0]  temp_ff, temp_in;

   // Clamp a 32-bit word into the signed range of the stored values
   function automatic logic signed [VALUE_WIDTH-1:0] sat_word(input logic signed [31:0] x);
      logic signed [63:0] xw;
      xw = 64'(x);
      if (VALUE_WIDTH >= 32) begin
         return VALUE_WIDTH'(x);
      end else if (xw > SAT_HI) begin
         return VALUE_WIDTH'(SAT_HI);
      end else if (xw < SAT_LO) begin
         return VALUE_WIDTH'(SAT_LO);
      end
      return VALUE_WIDTH'(x);
   endfunction

   always_comb begin
      init_a_in = init_a_ff;
      init_b_in = init_b_ff;
      rate_in   = rate_ff;
      temp_in   = temp_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_INIT_A:   init_a_in = $signed(csr_wdata[FIELD_W-1:0]);
            CSR_INIT_B:   init_b_in = $signed(csr_wdata[FIELD_W-1:0]);
            CSR_RATE:     rate_in   = csr_wdata[RATE_W-1:0];
            CSR_INV_TEMP: temp_in   = $signed(csr_wdata[TEMP_W-1:0]);
            default:      rate_in   = rate_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_a_ff <= '0;
         init_b_ff <= '0;
         rate_ff   <= '0;
         temp_ff   <= $signed(INV_TEMP_RESET);
      end else begin
         init_a_ff <= init_a_in;
         init_b_ff <= init_b_in;
         rate_ff   <= rate_in;
         temp_ff   <= temp_in;
      end
   end

   assign init_a_sat = sat_word(init_a_ff);
   assign init_b_sat = sat_word(init_b_ff);
   assign rate_eff   = (rate_ff > RATE_ONE) ? RATE_ONE : rate_ff;
   assign inv_temp   = temp_ff;

   // Hold the requester off only while the queue has no room
   assign req_stall   = q_status.full;
   assign q_push      = req_valid && !q_status.full;
   assign q_push_data = {req_first_trial, req_chose_b, sat_word(req_reward_value)};

endmodule

/* hw/rtl/drcp_back.sv */
// Back end: value update, logistic choice probability and response register.
// Depends on drcp_pkg; drains drcp_queue.
`timescale 1ns / 1ps

module drcp_back #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  drcp_pkg::q_status_type                q_status,
   output logic                                  q_pop,
   input  logic [VALUE_WIDTH+1:0]                q_pop_data,
   input  logic signed [VALUE_WIDTH-1:0]         init_a_sat,
   input  logic signed [VALUE_WIDTH-1:0]         init_b_sat,
   input  logic [drcp_pkg::RATE_W-1:0]           rate_eff,
   input  logic signed [drcp_pkg::TEMP_W-1:0]    inv_temp,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [drcp_pkg::PROB_W-1:0]           rsp_prob_b,
   output logic signed [drcp_pkg::FIELD_W-1:0]   rsp_value_a_out,
   output logic signed [drcp_pkg::FIELD_W-1:0]   rsp_value_b_out
);
   import drcp_pkg::*;

   localparam int DW  = VALUE_WIDTH + 1;     // reward minus value
   localparam int HW  = DW - 16;             // integer part of the step
   localparam int PHW = HW + RATE_W + 1;
   localparam int PLW = 16 + RATE_W;
   localparam int NW  = PHW + 1;
   localparam int EW  = (DW > CLAMP_W) ? DW : CLAMP_W;
   localparam int XLW = TEMP_W + 17;
   localparam logic signed [EW-1:0] DIFF_HI = EW'(64'sd1 <<< 38);
   localparam logic signed [EW-1:0] DIFF_LO = -DIFF_HI;

   back_state_type state_ff, state_in;

   logic signed [VALUE_WIDTH-1:0] value_a_ff, value_a_in;
   logic signed [VALUE_WIDTH-1:0] value_b_ff, value_b_in;
   logic signed [VALUE_WIDTH-1:0] base_a_ff, base_a_in;
   logic signed [VALUE_WIDTH-1:0] base_b_ff, base_b_in;
   logic signed [VALUE_WIDTH-1:0] v_ff, v_in;
   logic                          chose_b_ff, chose_b_in;
   logic signed [PHW-1:0]         prod_hi_ff, prod_hi_in;
   logic [PLW-1:0]                prod_lo_ff, prod_lo_in;
   logic signed [LOGIT_W-1:0]     xp_hi_ff, xp_hi_in;
   logic signed [XLW-1:0]         xp_lo_ff, xp_lo_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [PROB_W-1:0]             prob_ff;
   logic signed [FIELD_W-1:0]     out_a_ff, out_b_ff;

   logic                          load_mul, write_val, load_x, load_rsp, rsp_free;
   logic                          item_first, item_chose_b;
   logic signed [VALUE_WIDTH-1:0] item_reward;
   logic signed [DW-1:0]          step;
   logic signed [NW-1:0]          new_value_w;
   logic signed [VALUE_WIDTH-1:0] new_value;
   logic signed [EW-1:0]          diff_e;
   logic signed [CLAMP_W-1:0]     diff_c;
   logic signed [LOGIT_W-1:0]     logit;

   assign item_first   = q_pop_data[VALUE_WIDTH+1];
   assign item_chose_b = q_pop_data[VALUE_WIDTH];
   assign item_reward  = $signed(q_pop_data[VALUE_WIDTH-1:0]);
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE:   if (!q_status.empty) state_in = BACK_UPDATE;
         BACK_UPDATE: state_in = BACK_SCALE;
         BACK_SCALE:  state_in = BACK_EMIT;
         BACK_EMIT:   if (rsp_free) state_in = BACK_IDLE;
         default:     state_in = BACK_IDLE;
      endcase
   end

   // Strobes
   always_comb begin
      load_mul  = 1'b0;
      write_val = 1'b0;
      load_x    = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         BACK_IDLE:   load_mul  = !q_status.empty;
         BACK_UPDATE: write_val = 1'b1;
         BACK_SCALE:  load_x    = 1'b1;
         BACK_EMIT:   load_rsp  = rsp_free;
         default:     load_mul  = 1'b0;
      endcase
   end

   assign q_pop = load_mul;

   // Step one: reload on a first trial, split the step into two partial products
   always_comb begin
      base_a_in  = item_first ? init_a_sat : value_a_ff;
      base_b_in  = item_first ? init_b_sat : value_b_ff;
      chose_b_in = item_chose_b;
      v_in       = item_chose_b ? base_b_in : base_a_in;
      step       = DW'(item_reward) - DW'(v_in);
      prod_hi_in = $signed(step[DW-1:16]) * $signed({1'b0, rate_eff});
      prod_lo_in = step[15:0] * rate_eff;
   end

   // Step two: new value lies between old value and reward, so no overflow
   always_comb begin
      new_value_w = NW'(v_ff) + NW'(prod_hi_ff) + NW'($signed({1'b0, prod_lo_ff[PLW-1:16]}));
      new_value   = new_value_w[VALUE_WIDTH-1:0];
      value_a_in  = chose_b_ff ? base_a_ff : new_value;
      value_b_in  = chose_b_ff ? new_value : base_b_ff;
   end

   // Step three: clamp the difference and scale by the inverse temperature
   always_comb begin
      diff_e = EW'(value_b_ff) - EW'(value_a_ff);
      if (diff_e > DIFF_HI) begin
         diff_c = CLAMP_W'(DIFF_HI);
      end else if (diff_e < DIFF_LO) begin
         diff_c = CLAMP_W'(DIFF_LO);
      end else begin
         diff_c = CLAMP_W'(diff_e);
      end
      xp_hi_in = inv_temp * $signed(diff_c[CLAMP_W-1:16]);
      xp_lo_in = inv_temp * $signed({1'b0, diff_c[15:0]});
   end

   // Step four: Q16.16 logit and its logistic
   assign logit = xp_hi_ff + LOGIT_W'(xp_lo_ff >>> 16);

   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         value_a_ff   <= '0;
         value_b_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (write_val) begin
            value_a_ff <= value_a_in;
            value_b_ff <= value_b_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_mul) begin
         base_a_ff  <= base_a_in;
         base_b_ff  <= base_b_in;
         v_ff       <= v_in;
         chose_b_ff <= chose_b_in;
         prod_hi_ff <= prod_hi_in;
         prod_lo_ff <= prod_lo_in;
      end
      if (load_x) begin
         xp_hi_ff <= xp_hi_in;
         xp_lo_ff <= xp_lo_in;
      end
      if (load_rsp) begin
         prob_ff  <= logistic_q16(logit);
         out_a_ff <= FIELD_W'(value_a_ff);
         out_b_ff <= FIELD_W'(value_b_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prob_b      = prob_ff;
   assign rsp_value_a_out = out_a_ff;
   assign rsp_value_b_out = out_b_ff;

endmodule

/* hw/rtl/drcp_checker.sv */
// Port-level checks on the delta-rule choice block, bound to its top level.
// Depends on drcp_pkg and delta_rule_choice_probability_macros.svh.
`timescale 1ns / 1ps
`include "delta_rule_choice_probability_macros.svh"

module drcp_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [drcp_pkg::PROB_W-1:0]           rsp_prob_b,
   input logic signed [drcp_pkg::FIELD_W-1:0]   rsp_value_a_out,
   input logic signed [drcp_pkg::FIELD_W-1:0]   rsp_value_b_out
);
   import drcp_pkg::*;

   // A held response keeps its value
   `DRCP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_prob_b) && $stable(rsp_value_a_out) && $stable(rsp_value_b_out), "response dropped or changed while stalled")

   // Reset leaves no response pending
   `DRCP_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid, "response pending after reset")

   // Reset leaves the queue empty, so intake is open
   `DRCP_ASSERT_ALWAYS(a_req_reset, clock, reset |=> !req_stall, "request stalled after reset")

   // Equal option values give an even choice
   `DRCP_ASSERT(a_even_odds, clock, reset, rsp_valid && rsp_value_a_out == rsp_value_b_out |-> rsp_prob_b == 16'd32768, "equal values without even probability")

endmodule

bind delta_rule_choice_probability drcp_checker u_checker (.*);
